// ===== sv/pss_pkg.sv =====
package pss_pkg;

	localparam int COORD_W     = 24;
	localparam int STEP_W      = 23;
	localparam int GUARD       = 8;
	localparam int MAX_RESULTS = 64;

	localparam int K_W    = $clog2(MAX_RESULTS);
	localparam int MAG_W  = COORD_W + 1;
	localparam int D_W    = 2 * MAG_W + 1;
	localparam int ROOT_W = (D_W + 2 * GUARD + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int KS_W   = STEP_W + K_W;
	localparam int MS_W   = STEP_W + $clog2(MAX_RESULTS + 2);
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DIVN_W = KS_W + MAG_W + GUARD + 1;
	localparam int DIVC_W = $clog2(DIVN_W);
	localparam int SQC_W  = $clog2(ROOT_W);
	localparam int DATA_W = ((2 * COORD_W + 7) / 8) * 8;

	localparam logic [K_W-1:0] K_MAX = K_W'(MAX_RESULTS - 1);

	typedef enum logic [2:0] {
		MS_AX,
		MS_AY,
		MS_MS,
		MS_KX,
		MS_KY
	} mul_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIFF,
		ST_MAG_X,
		ST_MAG_Y,
		ST_DSUM,
		ST_CNT_MUL,
		ST_CNT_CMP,
		ST_ROOT_GO,
		ST_ROOT,
		ST_PT_NEXT,
		ST_PT_MULX,
		ST_PT_MULY,
		ST_PT_DIVY,
		ST_PT_WAIT,
		ST_PT_EMIT,
		ST_END_EMIT
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     diff;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     d_load;
		logic     d_add;
		logic     cnt_init;
		logic     cnt_step;
		logic     sqrt_start;
		logic     k_init;
		logic     k_step;
		logic     divx_start;
		logic     divy_start;
		logic     emit_mid;
		logic     emit_end;
	} cmd_t;

	typedef struct packed {
		logic path_new;
		logic cnt_less;
		logic cnt_full;
		logic cnt_zero;
		logic k_last;
		logic sqrt_busy;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/polyline_step_subdivider.sv =====
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata: point_x, point_y; tuser: path_start
// m_        out  m_tvalid/m_tready  tdata: out_x, out_y; tlast: run_last;
//                                   tuser: points_dropped
// cfg_      in   cfg_we             cfg_wdata: step_length
//
// a path start is emitted straight after the check; a later waypoint runs the
// compare passes and, when it has intermediate points, the bit-serial square root
// (one bit a cycle) and then, per intermediate point, the two bit-serial dividers
// (one quotient bit a cycle)
// one item is in work at a time; s_tready is high only while idle
// arst_n clears the controller, the stored point flag and the output valid
// a stalled m_tready holds the output register and the sequencer waits on it
module polyline_step_subdivider (
	input  logic                        clk,
	input  logic                        arst_n,
	// step_length
	input  logic                        cfg_we,
	input  logic [pss_pkg::STEP_W-1:0]  cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// point_x, point_y
	input  logic [pss_pkg::DATA_W-1:0]  s_tdata,
	// path_start
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// out_x, out_y
	output logic [pss_pkg::DATA_W-1:0]  m_tdata,
	// run_last
	output logic                        m_tlast,
	// points_dropped
	output logic                        m_tuser
);

	localparam int CW = pss_pkg::COORD_W;

	pss_pkg::cmd_t cmd;
	pss_pkg::sts_t sts;
	logic [CW-1:0] ox, oy;

	// sequencer: walks compare, root, and per-point multiply and divide steps
	pss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: stored point, shared multiplier, root and divider units
	pss_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_x      (s_tdata[CW-1:0]),
		.in_y      (s_tdata[2*CW-1:CW]),
		.in_start  (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_x     (ox),
		.out_y     (oy),
		.out_last  (m_tlast),
		.out_drop  (m_tuser)
	);

	// pack the output item, x in the low bits
	assign m_tdata = pss_pkg::DATA_W'({oy, ox});

endmodule

// ===== sv/pss_sqrt.sv =====
module pss_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pss_pkg::RAD_W-1:0]  rad,
	output logic                       busy,
	output logic [pss_pkg::ROOT_W-1:0] root
);

	logic [pss_pkg::RAD_W-1:0]  rad_q;
	logic [pss_pkg::ROOT_W:0]   rem_q;
	logic [pss_pkg::ROOT_W-1:0] root_q;
	logic [pss_pkg::SQC_W-1:0]  cnt_q;
	logic                       busy_q;

	logic [pss_pkg::ROOT_W+2:0] rem_n;
	logic [pss_pkg::ROOT_W+2:0] trial;
	logic                       take;

	// one result bit per cycle, two radicand bits consumed
	assign rem_n = {rem_q, rad_q[pss_pkg::RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign take  = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= pss_pkg::SQC_W'(pss_pkg::ROOT_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[pss_pkg::RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_n[pss_pkg::ROOT_W:0] - trial[pss_pkg::ROOT_W:0];
				root_q <= {root_q[pss_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n[pss_pkg::ROOT_W:0];
				root_q <= {root_q[pss_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ===== sv/pss_div.sv =====
module pss_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pss_pkg::DIVN_W-1:0]  num,
	input  logic [pss_pkg::ROOT_W-1:0]  den,
	output logic                        busy,
	output logic [pss_pkg::COORD_W-1:0] quo
);

	logic [pss_pkg::DIVN_W-1:0]  num_q;
	logic [pss_pkg::ROOT_W-1:0]  den_q;
	logic [pss_pkg::ROOT_W-1:0]  rem_q;
	logic [pss_pkg::COORD_W-1:0] quo_q;
	logic [pss_pkg::DIVC_W-1:0]  cnt_q;
	logic                        busy_q;

	logic [pss_pkg::ROOT_W:0] rem_sh;
	logic                     take;

	// restoring division, one quotient bit per cycle, low bits kept
	assign rem_sh = {rem_q, num_q[pss_pkg::DIVN_W-1]};
	assign take   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= pss_pkg::DIVC_W'(pss_pkg::DIVN_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[pss_pkg::DIVN_W-2:0], 1'b0};
			if (take) begin
				rem_q <= pss_pkg::ROOT_W'(rem_sh - {1'b0, den_q});
				quo_q <= {quo_q[pss_pkg::COORD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[pss_pkg::ROOT_W-1:0];
				quo_q <= {quo_q[pss_pkg::COORD_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== sv/pss_datapath.sv =====
module pss_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pss_pkg::STEP_W-1:0]  cfg_wdata,
	input  logic [pss_pkg::COORD_W-1:0] in_x,
	input  logic [pss_pkg::COORD_W-1:0] in_y,
	input  logic                        in_start,
	input  pss_pkg::cmd_t               cmd,
	output pss_pkg::sts_t               sts,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [pss_pkg::COORD_W-1:0] out_x,
	output logic [pss_pkg::COORD_W-1:0] out_y,
	output logic                        out_last,
	output logic                        out_drop
);

	localparam int CW = pss_pkg::COORD_W;

	logic [pss_pkg::STEP_W-1:0] step_q;
	logic [CW-1:0]              nx_q, ny_q, px_q, py_q;
	logic                       start_q, have_prev_q;
	logic [pss_pkg::MAG_W-1:0]  ax_q, ay_q;
	logic                       negx_q, negy_q;
	logic [pss_pkg::PROD_W-1:0] prod_q;
	logic [pss_pkg::D_W-1:0]    d_q;
	logic [pss_pkg::MS_W-1:0]   ms_q;
	logic [pss_pkg::K_W-1:0]    cnt_q, k_q;
	logic                       drop_q;
	logic [pss_pkg::KS_W-1:0]   ks_q;
	logic                       ov_q, ol_q, od_q;
	logic [CW-1:0]              ox_q, oy_q;

	logic [pss_pkg::STEP_W-1:0] s_eff;
	logic signed [CW:0]         dx, dy;
	logic [pss_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic [pss_pkg::ROOT_W-1:0] root;
	logic                       sq_busy, dvx_busy, dvy_busy;
	logic [pss_pkg::DIVN_W-1:0] div_num;
	logic [CW-1:0]              qx, qy;
	logic                       div_start_x, div_start_y;

	assign s_eff = (step_q == '0) ? pss_pkg::STEP_W'(1) : step_q;
	assign dx = $signed({nx_q[CW-1], nx_q}) - $signed({px_q[CW-1], px_q});
	assign dy = $signed({ny_q[CW-1], ny_q}) - $signed({py_q[CW-1], py_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			pss_pkg::MS_AX: begin
				mul_a = pss_pkg::MUL_W'(ax_q);
				mul_b = pss_pkg::MUL_W'(ax_q);
			end
			pss_pkg::MS_AY: begin
				mul_a = pss_pkg::MUL_W'(ay_q);
				mul_b = pss_pkg::MUL_W'(ay_q);
			end
			pss_pkg::MS_MS: begin
				mul_a = pss_pkg::MUL_W'(ms_q);
				mul_b = pss_pkg::MUL_W'(ms_q);
			end
			pss_pkg::MS_KX: begin
				mul_a = pss_pkg::MUL_W'(ks_q);
				mul_b = pss_pkg::MUL_W'(ax_q);
			end
			pss_pkg::MS_KY: begin
				mul_a = pss_pkg::MUL_W'(ks_q);
				mul_b = pss_pkg::MUL_W'(ay_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= pss_pkg::STEP_W'(256);
			have_prev_q <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			ov_q        <= 1'b0;
			cnt_q       <= '0;
			k_q         <= '0;
			drop_q      <= 1'b0;
		end else begin
			if (cfg_we)
				step_q <= cfg_wdata;
			if (cmd.load_in)
				drop_q <= 1'b0;
			if (cmd.cnt_init)
				cnt_q <= '0;
			else if (cmd.cnt_step) begin
				if (cnt_q == pss_pkg::K_MAX)
					drop_q <= 1'b1;
				else
					cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.k_init)
				k_q <= '0;
			else if (cmd.k_step)
				k_q <= k_q + 1'b1;
			if (cmd.emit_end) begin
				px_q        <= nx_q;
				py_q        <= ny_q;
				have_prev_q <= 1'b1;
			end
			if (cmd.emit_mid || cmd.emit_end)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			nx_q    <= in_x;
			ny_q    <= in_y;
			start_q <= in_start;
		end
		if (cmd.diff) begin
			negx_q <= dx[CW];
			negy_q <= dy[CW];
			ax_q   <= dx[CW] ? pss_pkg::MAG_W'(-dx) : pss_pkg::MAG_W'(dx);
			ay_q   <= dy[CW] ? pss_pkg::MAG_W'(-dy) : pss_pkg::MAG_W'(dy);
		end
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.d_load)
			d_q <= prod_q[pss_pkg::D_W-1:0];
		else if (cmd.d_add)
			d_q <= d_q + prod_q[pss_pkg::D_W-1:0];
		if (cmd.cnt_init)
			ms_q <= pss_pkg::MS_W'({s_eff, 1'b0});
		else if (cmd.cnt_step && cnt_q != pss_pkg::K_MAX)
			ms_q <= ms_q + pss_pkg::MS_W'(s_eff);
		if (cmd.k_init)
			ks_q <= '0;
		else if (cmd.k_step)
			ks_q <= ks_q + pss_pkg::KS_W'(s_eff);
		if (cmd.emit_mid) begin
			ox_q <= negx_q ? px_q - qx : px_q + qx;
			oy_q <= negy_q ? py_q - qy : py_q + qy;
			ol_q <= 1'b0;
			od_q <= 1'b0;
		end else if (cmd.emit_end) begin
			ox_q <= nx_q;
			oy_q <= ny_q;
			ol_q <= 1'b1;
			od_q <= drop_q;
		end
	end

	// scaled offset numerator plus half the divisor for rounding
	assign div_num = pss_pkg::DIVN_W'({prod_q[pss_pkg::KS_W+pss_pkg::MAG_W-1:0],
		{pss_pkg::GUARD{1'b0}}}) + pss_pkg::DIVN_W'(root >> 1);
	assign div_start_x = cmd.divx_start;
	assign div_start_y = cmd.divy_start;

	pss_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (pss_pkg::RAD_W'({d_q, {(2 * pss_pkg::GUARD){1'b0}}})),
		.busy   (sq_busy),
		.root   (root)
	);

	pss_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_x),
		.num    (div_num),
		.den    (root),
		.busy   (dvx_busy),
		.quo    (qx)
	);

	pss_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_y),
		.num    (div_num),
		.den    (root),
		.busy   (dvy_busy),
		.quo    (qy)
	);

	always_comb begin
		sts.path_new  = start_q || !have_prev_q;
		sts.cnt_less  = prod_q < pss_pkg::PROD_W'(d_q);
		sts.cnt_full  = cnt_q == pss_pkg::K_MAX;
		sts.cnt_zero  = cnt_q == '0;
		sts.k_last    = k_q == cnt_q;
		sts.sqrt_busy = sq_busy;
		sts.div_busy  = dvx_busy || dvy_busy;
		sts.out_free  = !ov_q || out_ready;
	end

	assign out_valid = ov_q;
	assign out_x     = ox_q;
	assign out_y     = oy_q;
	assign out_last  = ol_q;
	assign out_drop  = od_q;

`ifndef SYNTH
	a_drop_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> cnt_q == pss_pkg::K_MAX)
		else $error("drop flag set below the result limit");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_mid || cmd.emit_end) |-> (!ov_q || out_ready))
		else $error("output register overwritten while held");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_mid |-> (k_q <= cnt_q && k_q != '0))
		else $error("intermediate index out of range");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_mid |-> !(dvx_busy || dvy_busy || sq_busy))
		else $error("point emitted while a unit is busy");
`endif

endmodule

// ===== sv/pss_ctrl.sv =====
module pss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pss_pkg::sts_t sts,
	output pss_pkg::cmd_t cmd
);

	pss_pkg::state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pss_pkg::ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pss_pkg::ST_IDLE:    if (in_valid) state_n = pss_pkg::ST_CHECK;
			pss_pkg::ST_CHECK:   state_n = sts.path_new ? pss_pkg::ST_END_EMIT
			                                             : pss_pkg::ST_DIFF;
			pss_pkg::ST_DIFF:    state_n = pss_pkg::ST_MAG_X;
			pss_pkg::ST_MAG_X:   state_n = pss_pkg::ST_MAG_Y;
			pss_pkg::ST_MAG_Y:   state_n = pss_pkg::ST_DSUM;
			pss_pkg::ST_DSUM:    state_n = pss_pkg::ST_CNT_MUL;
			pss_pkg::ST_CNT_MUL: state_n = pss_pkg::ST_CNT_CMP;
			pss_pkg::ST_CNT_CMP: begin
				if (sts.cnt_less && !sts.cnt_full)
					state_n = pss_pkg::ST_CNT_MUL;
				else if (sts.cnt_less)
					state_n = pss_pkg::ST_ROOT_GO;
				else if (sts.cnt_zero)
					state_n = pss_pkg::ST_END_EMIT;
				else
					state_n = pss_pkg::ST_ROOT_GO;
			end
			pss_pkg::ST_ROOT_GO: state_n = pss_pkg::ST_ROOT;
			pss_pkg::ST_ROOT:    if (!sts.sqrt_busy) state_n = pss_pkg::ST_PT_NEXT;
			pss_pkg::ST_PT_NEXT: state_n = pss_pkg::ST_PT_MULX;
			pss_pkg::ST_PT_MULX: state_n = pss_pkg::ST_PT_MULY;
			pss_pkg::ST_PT_MULY: state_n = pss_pkg::ST_PT_DIVY;
			pss_pkg::ST_PT_DIVY: state_n = pss_pkg::ST_PT_WAIT;
			pss_pkg::ST_PT_WAIT: if (!sts.div_busy) state_n = pss_pkg::ST_PT_EMIT;
			pss_pkg::ST_PT_EMIT: begin
				if (sts.out_free)
					state_n = sts.k_last ? pss_pkg::ST_END_EMIT : pss_pkg::ST_PT_NEXT;
			end
			pss_pkg::ST_END_EMIT: if (sts.out_free) state_n = pss_pkg::ST_IDLE;
			default:             state_n = pss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = pss_pkg::MS_AX;
		in_ready = 1'b0;
		unique case (state_q)
			pss_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			pss_pkg::ST_DIFF: cmd.diff = 1'b1;
			pss_pkg::ST_MAG_X: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pss_pkg::MS_AX;
			end
			pss_pkg::ST_MAG_Y: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pss_pkg::MS_AY;
				cmd.d_load  = 1'b1;
			end
			pss_pkg::ST_DSUM: begin
				cmd.d_add    = 1'b1;
				cmd.cnt_init = 1'b1;
			end
			pss_pkg::ST_CNT_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pss_pkg::MS_MS;
			end
			pss_pkg::ST_CNT_CMP: cmd.cnt_step = sts.cnt_less;
			pss_pkg::ST_ROOT_GO: begin
				cmd.sqrt_start = 1'b1;
				cmd.k_init     = 1'b1;
			end
			pss_pkg::ST_PT_NEXT: cmd.k_step = 1'b1;
			pss_pkg::ST_PT_MULX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pss_pkg::MS_KX;
			end
			pss_pkg::ST_PT_MULY: begin
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = pss_pkg::MS_KY;
				cmd.divx_start = 1'b1;
			end
			pss_pkg::ST_PT_DIVY: cmd.divy_start = 1'b1;
			pss_pkg::ST_PT_EMIT: cmd.emit_mid = sts.out_free;
			pss_pkg::ST_END_EMIT: cmd.emit_end = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== test/pss_checker.sv =====
`timescale 1ns / 100ps

module pss_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pss_pkg::STEP_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [pss_pkg::DATA_W-1:0] s_tdata,
	input  logic                       s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [pss_pkg::DATA_W-1:0] m_tdata,
	input  logic                       m_tlast,
	input  logic                       m_tuser,
	output int                         fail_count,
	output int                         pending
);

	typedef struct packed {
		logic [pss_pkg::COORD_W-1:0] x;
		logic [pss_pkg::COORD_W-1:0] y;
		logic                        last;
		logic                        dropped;
	} point_t;

	point_t                        expected_points[$];
	logic [pss_pkg::STEP_W-1:0]    spacing;
	logic [pss_pkg::COORD_W-1:0]   held_x, held_y;
	logic                          held_valid;

	assign pending = expected_points.size();

	// rounded offset along one axis for the k-th intermediate point
	function automatic logic [pss_pkg::COORD_W-1:0] offset_point(
			input logic [pss_pkg::COORD_W-1:0] base,
			input logic [63:0] mag, input logic neg, input logic [63:0] ks,
			input logic [63:0] root);
		logic [127:0] num;
		logic [127:0] q;
		num = ((128'(ks) * 128'(mag)) << pss_pkg::GUARD) + 128'(root >> 1);
		q = num / 128'(root);
		return neg ? base - pss_pkg::COORD_W'(q) : base + pss_pkg::COORD_W'(q);
	endfunction

	task automatic predict_points(input logic [pss_pkg::COORD_W-1:0] nx,
			input logic [pss_pkg::COORD_W-1:0] ny, input logic start);
		logic signed [63:0] dx, dy;
		logic [63:0]  ax, ay, s, ms, root, trial;
		logic [127:0] dist2, rad;
		int count, n;
		point_t p;
		s = (spacing == 0) ? 64'd1 : 64'(spacing);
		if (start || !held_valid) begin
			p = '{nx, ny, 1'b1, 1'b0};
			expected_points.push_back(p);
		end else begin
			dx = 64'(signed'(nx)) - 64'(signed'(held_x));
			dy = 64'(signed'(ny)) - 64'(signed'(held_y));
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			dist2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
			count = 0;
			for (int m = 2; count < pss_pkg::MAX_RESULTS; m++) begin
				ms = 64'(m) * s;
				if (!(128'(ms) * 128'(ms) < dist2))
					break;
				count++;
			end
			n = (count > pss_pkg::MAX_RESULTS - 1) ? pss_pkg::MAX_RESULTS - 1 : count;
			if (n > 0) begin
				rad = dist2 << (2 * pss_pkg::GUARD);
				root = 0;
				for (int b = 63; b >= 0; b--) begin
					trial = root | (64'd1 << b);
					if (!(rad < 128'(trial) * 128'(trial)))
						root = trial;
				end
				for (int k = 1; k <= n; k++) begin
					p.x = offset_point(held_x, ax, dx < 0, 64'(k) * s, root);
					p.y = offset_point(held_y, ay, dy < 0, 64'(k) * s, root);
					p.last = 1'b0;
					p.dropped = 1'b0;
					expected_points.push_back(p);
				end
			end
			p = '{nx, ny, 1'b1, count > pss_pkg::MAX_RESULTS - 1};
			expected_points.push_back(p);
		end
		held_x = nx;
		held_y = ny;
		held_valid = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_t got, want;
		if (!arst_n) begin
			spacing    <= pss_pkg::STEP_W'(256);
			held_x     = '0;
			held_y     = '0;
			held_valid = 1'b0;
			fail_count <= 0;
			expected_points.delete();
		end else begin
			if (cfg_we)
				spacing <= cfg_wdata;
			if (s_tvalid && s_tready)
				predict_points(s_tdata[pss_pkg::COORD_W-1:0],
					s_tdata[2*pss_pkg::COORD_W-1:pss_pkg::COORD_W], s_tuser);
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[pss_pkg::COORD_W-1:0],
					m_tdata[2*pss_pkg::COORD_W-1:pss_pkg::COORD_W], m_tlast, m_tuser};
				if (expected_points.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected item x=%h y=%h last=%b drop=%b",
							got.x, got.y, got.last, got.dropped);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_points.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch exp x=%h y=%h l=%b d=%b got x=%h y=%h l=%b d=%b",
								want.x, want.y, want.last, want.dropped,
								got.x, got.y, got.last, got.dropped);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== test/tb_polyline_step_subdivider.sv =====
`timescale 1ns / 100ps

module tb_polyline_step_subdivider;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [pss_pkg::STEP_W-1:0]   cfg_wdata = '0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [pss_pkg::DATA_W-1:0]   s_tdata = '0;
	logic                         s_tuser = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [pss_pkg::DATA_W-1:0]   m_tdata;
	logic                         m_tlast;
	logic                         m_tuser;
	int                           fail_count;
	int                           pending;
	// receiver hold-off requested by the stimulus
	bit                           hold_sink = 1'b0;
	int                           sink_mode = 0;

	always #2 clk = ~clk;

	polyline_step_subdivider dut (.*);

	pss_checker checker_i (.*);

	// receiver: stall pattern of its own, with a long hold-off when asked
	initial begin
		int hold_count;
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				m_tready <= 1'b0;
				for (hold_count = 0; hold_count < 3000; hold_count++)
					@(posedge clk);
				hold_sink = 1'b0;
			end
			case (sink_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 1) == 0);
			endcase
			if ($urandom_range(0, 63) == 0)
				sink_mode = $urandom_range(0, 2);
		end
	end

	// offer one item and wait until it is taken
	task automatic send_point(input logic [pss_pkg::COORD_W-1:0] x,
			input logic [pss_pkg::COORD_W-1:0] y, input logic start);
		s_tvalid <= 1'b1;
		s_tdata  <= {x, y} == 0 ? '0 : pss_pkg::DATA_W'({y, x});
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain_all;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_spacing(input logic [pss_pkg::STEP_W-1:0] value);
		drain_all();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly segments within 35 spacings per axis, some within 4, some long random ones
	function automatic logic [pss_pkg::COORD_W-1:0] near_coord(
			input logic [pss_pkg::COORD_W-1:0] base,
			input logic [pss_pkg::STEP_W-1:0] sp);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return pss_pkg::COORD_W'($urandom);
		if (r < 3)
			return base + pss_pkg::COORD_W'($signed($urandom_range(0, 8 * sp)) - 4 * sp);
		return base + pss_pkg::COORD_W'($signed($urandom_range(0, 70 * sp)) - 35 * sp);
	endfunction

	initial begin
		logic [pss_pkg::COORD_W-1:0] px, py;
		logic [pss_pkg::STEP_W-1:0]  sp;
		int burst;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no stored point, short segment, result limit, extremes
		send_point(24'h000100, 24'h000200, 1'b0);
		send_point(24'h000180, 24'h000200, 1'b0);
		send_point(24'h000180, 24'h000500, 1'b0);
		send_point(24'h000000, 24'h000000, 1'b0);
		send_point(24'h7fffff, 24'h7fffff, 1'b1);
		send_point(24'h800000, 24'h800000, 1'b0);
		send_point(24'h7fffff, 24'h800000, 1'b0);
		send_point(24'h001000, 24'hfff000, 1'b1);
		send_point(24'hffe000, 24'h003000, 1'b0);
		send_point(24'hffe300, 24'h003000, 1'b0);
		write_spacing('0);
		send_point(24'h000000, 24'h000000, 1'b1);
		send_point(24'h000005, 24'hfffff9, 1'b0);
		send_point(24'h000010, 24'hfffff0, 1'b0);
		write_spacing(pss_pkg::STEP_W'(8388607));
		send_point(24'h800000, 24'h7fffff, 1'b0);
		send_point(24'h7fffff, 24'h800000, 1'b0);
		send_point(24'h000000, 24'h000000, 1'b0);

		// long hold-off on the receiver while the sender keeps offering
		write_spacing(pss_pkg::STEP_W'(64));
		hold_sink = 1'b1;
		send_point(24'h000000, 24'h000000, 1'b1);
		for (int i = 0; i < 4; i++)
			send_point(pss_pkg::COORD_W'(i * 2000), pss_pkg::COORD_W'(-i * 900), 1'b0);

		px = 0;
		py = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: sp = pss_pkg::STEP_W'(256);
				1: sp = pss_pkg::STEP_W'($urandom_range(1, 40));
				2: sp = pss_pkg::STEP_W'($urandom_range(300, 5000));
				default: sp = pss_pkg::STEP_W'($urandom_range(1, 8388607));
			endcase
			write_spacing(sp);
			for (int i = 0; i < 100; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && i < 100; b++, i++) begin
					if (phase == 3 && $urandom_range(0, 1)) begin
						px = pss_pkg::COORD_W'($urandom);
						py = pss_pkg::COORD_W'($urandom);
					end else begin
						px = near_coord(px, sp == 0 ? pss_pkg::STEP_W'(1) : sp);
						py = near_coord(py, sp == 0 ? pss_pkg::STEP_W'(1) : sp);
					end
					send_point(px, py, $urandom_range(0, 15) == 0);
				end
				s_tvalid <= 1'b0;
				repeat ($urandom_range(0, 20)) @(posedge clk);
			end
		end

		drain_all();
		if (fail_count == 0)
			$display("[polyline_step_subdivider] OK");
		else
			$display("[polyline_step_subdivider] ERROR");
		$finish;
	end

	initial begin
		#100ms;
		$display("[polyline_step_subdivider] ERROR");
		$finish;
	end

endmodule
